// ===== rtl/sep3_pkg.sv =====
// Shared constants, types and rounding helpers for the separable 3x3 filter.
package sep3_pkg;

    localparam int MAX_WIDTH      = 2048;
    localparam int PIXEL_BITS     = 16;
    localparam int COEF_FRAC_BITS = 14;
    localparam int MID_BITS       = PIXEL_BITS + 4;
    localparam int COEF_BITS      = 16;
    localparam int COL_BITS       = 11;
    localparam int ROW_BITS       = 16;
    localparam int WIDTH_BITS     = 12;
    localparam int ADDR_BITS      = $clog2(MAX_WIDTH);
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 16;
    localparam int H_PROD_BITS    = COEF_BITS + PIXEL_BITS;
    localparam int H_SUM_BITS     = H_PROD_BITS + 2;
    localparam int V_PROD_BITS    = COEF_BITS + MID_BITS;
    localparam int V_SUM_BITS     = V_PROD_BITS + 2;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int OUT_DATA_BITS  = 48;

    localparam logic [CFG_IDX_BITS-1:0] CFG_H_LEFT   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_H_CENTER = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_H_RIGHT  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_V_TOP    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_V_MIDDLE = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_V_BOTTOM = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH    = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT   = 3'd7;

    typedef struct packed {
        logic signed [COEF_BITS-1:0] h_left;
        logic signed [COEF_BITS-1:0] h_center;
        logic signed [COEF_BITS-1:0] h_right;
        logic signed [COEF_BITS-1:0] v_top;
        logic signed [COEF_BITS-1:0] v_middle;
        logic signed [COEF_BITS-1:0] v_bottom;
        logic [WIDTH_BITS-1:0]       width;
        logic [ROW_BITS-1:0]         height;
    } t_cfg;

    // One finished column: horizontal taps and where it lands
    typedef struct packed {
        logic [COL_BITS-1:0]          col;
        logic [ROW_BITS-1:0]          row;
        logic                         first_row;
        logic                         last_row;
        logic                         final_job;
        logic signed [PIXEL_BITS-1:0] px_l;
        logic signed [PIXEL_BITS-1:0] px_c;
        logic signed [PIXEL_BITS-1:0] px_r;
    } t_job;

    localparam int JOB_BITS = $bits(t_job);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HSUM,
        ST_VMUL,
        ST_VOUT,
        ST_WRITE
    } t_back_state;

    function automatic logic signed [MID_BITS-1:0] round_sat_mid(
        input logic signed [H_SUM_BITS-1:0] s
    );
        logic signed [H_SUM_BITS-1:0] t;
        logic signed [H_SUM_BITS-1:0] hi;
        logic signed [H_SUM_BITS-1:0] lo;
        hi = H_SUM_BITS'((64'sd1 <<< (MID_BITS - 1)) - 64'sd1);
        lo = ~hi;
        t  = (s + H_SUM_BITS'(64'sd1 <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
        if (t > hi) begin
            t = hi;
        end else if (t < lo) begin
            t = lo;
        end
        return t[MID_BITS-1:0];
    endfunction

    function automatic logic signed [PIXEL_BITS-1:0] round_sat_pix(
        input logic signed [V_SUM_BITS-1:0] s
    );
        logic signed [V_SUM_BITS-1:0] t;
        logic signed [V_SUM_BITS-1:0] hi;
        logic signed [V_SUM_BITS-1:0] lo;
        hi = V_SUM_BITS'((64'sd1 <<< (PIXEL_BITS - 1)) - 64'sd1);
        lo = ~hi;
        t  = (s + V_SUM_BITS'(64'sd1 <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
        if (t > hi) begin
            t = hi;
        end else if (t < lo) begin
            t = lo;
        end
        return t[PIXEL_BITS-1:0];
    endfunction

endpackage

// ===== rtl/separable_3x3_convolution_top.sv =====
// Top level of the separable 3x3 filter with replicated borders.
//
//  channel   direction  signals                         payload
//  s_axis    in         tvalid, tready, tdata[15:0]     pixel_in
//  m_axis    out        tvalid, tready, tdata, tlast    pixel_out, column, row; last_of_run
//  cfg       in         valid, ready, index, data       coefficient, width, height writes
//
// Each finished column takes the back part through its steps in order: pop and multiply,
// sum with line store read, vertical multiply, output, store write. On the first row only
// the stores are written; on the last row the multiply and output run twice before the store
// write. The right edge finishes two columns; the next job is popped only back in idle.
// Reset is synchronous, active low; it restores identity taps and 640x480.
// The input stalls when the four-entry job queue fills; the output register holds a
// result until taken while the back part keeps working up to the next result.
module separable_3x3_convolution_top
    import sep3_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    input  logic [PIXEL_BITS-1:0]    i_s_axis_tdata,   // [15:0] pixel_in
    output logic                     o_m_axis_tvalid,
    input  logic                     i_m_axis_tready,
    output logic [OUT_DATA_BITS-1:0] o_m_axis_tdata,   // [15:0] pixel_out, [26:16] column,
                                                       // [42:27] row, [47:43] zero
    output logic                     o_m_axis_tlast,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    t_cfg                  r_cfg;
    logic                  q_push;
    t_job                  q_in;
    logic                  q_pop;
    t_job                  q_head;
    logic                  q_empty;
    logic                  q_full;
    logic [PIXEL_BITS-1:0] out_pixel;
    logic [COL_BITS-1:0]   out_col;
    logic [ROW_BITS-1:0]   out_row;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.h_left   <= '0;
            r_cfg.h_center <= COEF_BITS'(1 << COEF_FRAC_BITS);
            r_cfg.h_right  <= '0;
            r_cfg.v_top    <= '0;
            r_cfg.v_middle <= COEF_BITS'(1 << COEF_FRAC_BITS);
            r_cfg.v_bottom <= '0;
            r_cfg.width    <= WIDTH_BITS'(640);
            r_cfg.height   <= ROW_BITS'(480);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_H_LEFT:   r_cfg.h_left   <= i_cfg_data;
                CFG_H_CENTER: r_cfg.h_center <= i_cfg_data;
                CFG_H_RIGHT:  r_cfg.h_right  <= i_cfg_data;
                CFG_V_TOP:    r_cfg.v_top    <= i_cfg_data;
                CFG_V_MIDDLE: r_cfg.v_middle <= i_cfg_data;
                CFG_V_BOTTOM: r_cfg.v_bottom <= i_cfg_data;
                CFG_WIDTH:    r_cfg.width    <= i_cfg_data[WIDTH_BITS-1:0];
                CFG_HEIGHT:   r_cfg.height   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    sep3_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_pixel (i_s_axis_tdata),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_job   (q_in)
    );

    sep3_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    sep3_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_empty (q_empty),
        .i_head  (q_head),
        .o_pop   (q_pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_pixel (out_pixel),
        .o_col   (out_col),
        .o_row   (out_row),
        .o_last  (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {
        (OUT_DATA_BITS - PIXEL_BITS - COL_BITS - ROW_BITS)'(0), out_row, out_col, out_pixel
    };

endmodule

// ===== rtl/sep3_ram.sv =====
// Generic single-port RAM with registered read.
module sep3_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/sep3_fifo.sv =====
// Short job queue between the front and back parts.
module sep3_fifo
    import sep3_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_head,
    output logic o_empty,
    output logic o_full
);

    t_job                      r_slot [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] r_wr;
    logic [QUEUE_PTR_BITS-1:0] r_rd;
    logic [QUEUE_PTR_BITS:0]   r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
    assign o_head  = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/sep3_front.sv =====
// Front part: take pixels, track position, issue one job per finished column.
module sep3_front
    import sep3_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [PIXEL_BITS-1:0] i_pixel,
    input  logic                  i_full,
    output logic                  o_push,
    output t_job                  o_job
);

    logic signed [PIXEL_BITS-1:0] r_prev;
    logic signed [PIXEL_BITS-1:0] r_prev2;
    logic [COL_BITS-1:0]          r_col;
    logic [ROW_BITS-1:0]          r_row;
    logic                         r_pend;
    t_job                         r_job_b;

    logic [WIDTH_BITS-1:0]        w_eff;
    logic [ROW_BITS-1:0]          h_eff;
    logic                         last_col;
    logic                         last_row;
    logic                         has_a;
    logic                         accept;
    logic signed [PIXEL_BITS-1:0] pix;
    logic signed [PIXEL_BITS-1:0] prev_eff;
    logic signed [PIXEL_BITS-1:0] prev2_eff;
    t_job                         job_a;
    t_job                         job_b;

    always_comb begin
        if (i_cfg.width == '0) begin
            w_eff = WIDTH_BITS'(1);
        end else if (i_cfg.width > WIDTH_BITS'(MAX_WIDTH)) begin
            w_eff = WIDTH_BITS'(MAX_WIDTH);
        end else begin
            w_eff = i_cfg.width;
        end
        h_eff    = (i_cfg.height == '0) ? ROW_BITS'(1) : i_cfg.height;
        last_col = WIDTH_BITS'(r_col) >= (w_eff - 1'b1);
        last_row = r_row >= (h_eff - 1'b1);
        has_a    = (r_col != '0);
        pix      = $signed(i_pixel);
        prev_eff  = has_a ? r_prev  : pix;
        prev2_eff = has_a ? r_prev2 : pix;

        job_a.col       = r_col - 1'b1;
        job_a.row       = r_row;
        job_a.first_row = (r_row == '0);
        job_a.last_row  = last_row;
        job_a.final_job = !last_col;
        job_a.px_l      = prev2_eff;
        job_a.px_c      = prev_eff;
        job_a.px_r      = pix;

        job_b.col       = r_col;
        job_b.row       = r_row;
        job_b.first_row = (r_row == '0);
        job_b.last_row  = last_row;
        job_b.final_job = 1'b1;
        job_b.px_l      = prev_eff;
        job_b.px_c      = pix;
        job_b.px_r      = pix;

        o_ready = !r_pend && !i_full;
        accept  = i_valid && o_ready;
        if (r_pend) begin
            o_push = !i_full;
            o_job  = r_job_b;
        end else begin
            o_push = accept && (has_a || last_col);
            o_job  = has_a ? job_a : job_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_job_b <= job_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_prev2 <= '0;
            r_col   <= '0;
            r_row   <= '0;
            r_pend  <= 1'b0;
        end else begin
            if (r_pend && !i_full) begin
                r_pend <= 1'b0;
            end
            if (accept) begin
                r_prev2 <= prev_eff;
                r_prev  <= pix;
                // hold the right-edge column until the queue takes it
                r_pend  <= has_a && last_col;
                if (last_col) begin
                    r_col <= '0;
                    r_row <= last_row ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
        end
    end

endmodule

// ===== rtl/sep3_back.sv =====
// Back part: horizontal sum, line stores, vertical taps, output register.
module sep3_back
    import sep3_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  logic                  i_empty,
    input  t_job                  i_head,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [PIXEL_BITS-1:0] o_pixel,
    output logic [COL_BITS-1:0]   o_col,
    output logic [ROW_BITS-1:0]   o_row,
    output logic                  o_last
);

    t_back_state                   r_state;
    t_back_state                   n_state;
    t_job                          r_job;
    logic signed [H_PROD_BITS-1:0] r_hp0, r_hp1, r_hp2;
    logic signed [V_PROD_BITS-1:0] r_vp0, r_vp1, r_vp2;
    logic signed [MID_BITS-1:0]    r_h;
    logic signed [MID_BITS-1:0]    r_old;
    logic signed [MID_BITS-1:0]    r_new;
    logic                          r_second;
    logic                          r_out_valid;
    logic [PIXEL_BITS-1:0]         r_pixel;
    logic [COL_BITS-1:0]           r_col;
    logic [ROW_BITS-1:0]           r_row;
    logic                          r_last;

    logic [ADDR_BITS-1:0]          ram_addr;
    logic                          ram_we;
    logic [MID_BITS-1:0]           old_rdata;
    logic [MID_BITS-1:0]           new_rdata;
    logic signed [MID_BITS-1:0]    old_eff;
    logic signed [MID_BITS-1:0]    new_eff;
    logic signed [H_SUM_BITS-1:0]  h_sum;
    logic signed [V_SUM_BITS-1:0]  v_sum;
    logic                          slot_free;

    sep3_ram #(.WIDTH(MID_BITS), .DEPTH(MAX_WIDTH)) u_older (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (new_eff),
        .o_rdata (old_rdata)
    );

    sep3_ram #(.WIDTH(MID_BITS), .DEPTH(MAX_WIDTH)) u_newer (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (r_h),
        .o_rdata (new_rdata)
    );

    always_comb begin
        // the first row stands in for its own top neighbors
        old_eff   = r_job.first_row ? r_h : r_old;
        new_eff   = r_job.first_row ? r_h : r_new;
        h_sum     = H_SUM_BITS'(r_hp0) + H_SUM_BITS'(r_hp1) + H_SUM_BITS'(r_hp2);
        v_sum     = V_SUM_BITS'(r_vp0) + V_SUM_BITS'(r_vp1) + V_SUM_BITS'(r_vp2);
        slot_free = !r_out_valid || i_ready;
        ram_we    = (r_state == ST_WRITE);
        ram_addr  = (r_state == ST_WRITE) ? r_job.col[ADDR_BITS-1:0]
                                          : i_head.col[ADDR_BITS-1:0];
        o_pop     = 1'b0;
        n_state   = r_state;
        case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = ST_HSUM;
                end
            end
            ST_HSUM: begin
                n_state = (r_job.first_row && !r_job.last_row) ? ST_WRITE : ST_VMUL;
            end
            ST_VMUL: begin
                n_state = ST_VOUT;
            end
            ST_VOUT: begin
                if (slot_free) begin
                    n_state = (!r_second && r_job.last_row) ? ST_VMUL : ST_WRITE;
                end
            end
            ST_WRITE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_job <= i_head;
                r_hp0 <= $signed(i_cfg.h_left)   * $signed(i_head.px_l);
                r_hp1 <= $signed(i_cfg.h_center) * $signed(i_head.px_c);
                r_hp2 <= $signed(i_cfg.h_right)  * $signed(i_head.px_r);
            end
            ST_HSUM: begin
                r_h      <= round_sat_mid(h_sum);
                r_old    <= $signed(old_rdata);
                r_new    <= $signed(new_rdata);
                r_second <= r_job.first_row;
            end
            ST_VMUL: begin
                if (!r_second) begin
                    r_vp0 <= $signed(i_cfg.v_top)    * old_eff;
                    r_vp1 <= $signed(i_cfg.v_middle) * new_eff;
                end else begin
                    // bottom row: current row stands in below
                    r_vp0 <= $signed(i_cfg.v_top)    * new_eff;
                    r_vp1 <= $signed(i_cfg.v_middle) * r_h;
                end
                r_vp2 <= $signed(i_cfg.v_bottom) * r_h;
            end
            ST_VOUT: begin
                if (slot_free && !r_second && r_job.last_row) begin
                    r_second <= 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_VOUT && slot_free) begin
            r_pixel <= round_sat_pix(v_sum);
            r_col   <= r_job.col;
            r_row   <= r_second ? r_job.row : r_job.row - 1'b1;
            r_last  <= r_job.final_job && (r_second || !r_job.last_row);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_VOUT && slot_free) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid = r_out_valid;
    assign o_pixel = r_pixel;
    assign o_col   = r_col;
    assign o_row   = r_row;
    assign o_last  = r_last;

endmodule
